// File: sv/lmfe_pkg.sv
// shared types, codes and helper functions of the lin master frame engine
package lmfe_pkg;

    localparam int DATA_BYTES = 8;

    // opcodes of an input item
    localparam logic [2:0] OP_START_TX = 3'd0;
    localparam logic [2:0] OP_START_RX = 3'd1;
    localparam logic [2:0] OP_BYTE     = 3'd2;
    localparam logic [2:0] OP_BREAK    = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    // completion codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_SENT     = 3'd1;
    localparam logic [2:0] ST_RECEIVED = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // baud change requests
    localparam logic [1:0] BAUD_KEEP    = 2'd0;
    localparam logic [1:0] BAUD_SLOW    = 2'd1;
    localparam logic [1:0] BAUD_RESTORE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SYNC    = 2'd1;
    localparam logic [1:0] REG_BRKMODE = 2'd2;

    localparam logic [5:0] ID_MASK        = 6'h3F;
    localparam logic [7:0] BREAK_BYTE     = 8'h00;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0] SYNC_RESET     = 8'hAA;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_BREAK = 6'b000010,
        PH_SYNC  = 6'b000100,
        PH_PID   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [5:0]  frame_id;
        logic [3:0]  length;
        logic        enhanced;
        logic [63:0] payload;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] timeout_limit;
        logic [7:0]  sync_byte;
        logic        hw_break;
    } cfg_t;

    typedef struct packed {
        phase_t                          phase;
        logic                            sending;
        logic [7:0]                      protected_id;
        logic [3:0]                      frame_length;
        logic [3:0]                      bytes_left;
        logic [DATA_BYTES-1:0][7:0]      data_store;
        logic [63:0]                     tx_shift;
        logic [7:0]                      running_sum;
        logic                            use_enhanced;
        logic [15:0]                     idle_ticks;
    } state_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [1:0]  baud_select;
        logic        break_request;
        logic [2:0]  done_status;
        logic [63:0] rx_payload;
        logic [7:0]  done_pid;
        logic [3:0]  done_length;
    } result_t;

    localparam state_t IDLE_STATE = '{
        phase:        PH_IDLE,
        sending:      1'b0,
        protected_id: 8'd0,
        frame_length: 4'd0,
        bytes_left:   4'd0,
        data_store:   '0,
        tx_shift:     64'd0,
        running_sum:  8'd0,
        use_enhanced: 1'b1,
        idle_ticks:   16'd0
    };

    // lin end-around carry add
    function automatic logic [7:0] carry_add(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, b};
        if (t > 9'd255)
        begin
            t = t - 9'd255;
        end
        return t[7:0];
    endfunction

    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

endpackage

// File: sv/lin_master_frame_engine_top.sv
// lin master frame engine: item register, step logic, frame state and result register
//
// items come in on the in channel (in_valid / in_stall) and every item gives
// exactly one result on the out channel (out_valid / out_stall). an item first
// lands in an input register; when the held item moves on, the step logic updates
// the frame state and loads the result register. with no stall the engine takes
// one item per cycle.
// when out_stall holds a result, the input register still takes one more item;
// after that in_stall rises until the result is taken. nothing is dropped.
// start items abort any frame in progress without a status.
// configuration goes through cfg_valid / cfg_ready (always ready) with a register
// index on cfg_index and the value on cfg_data: 0 timeout limit, 1 sync byte,
// 2 break mode. write it only while the engine is idle.
// reset (rst_n low) empties both registers, puts the frame state to idle and
// loads timeout 1000, sync byte 0xaa and break by slow baud.
module lin_master_frame_engine_top
    import lmfe_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [5:0]  frame_id,
    input  logic [3:0]  length,
    input  logic        enhanced,
    input  logic [63:0] payload,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic [1:0]  baud_select,
    output logic        break_request,
    output logic [2:0]  done_status,
    output logic [63:0] rx_payload,
    output logic [7:0]  done_pid,
    output logic [3:0]  done_length
);

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit <= TIMEOUT_RESET;
            cfg_reg.sync_byte     <= SYNC_RESET;
            cfg_reg.hw_break      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TIMEOUT: cfg_reg.timeout_limit <= cfg_data;
                REG_SYNC:    cfg_reg.sync_byte     <= cfg_data[7:0];
                REG_BRKMODE: cfg_reg.hw_break      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // the held item moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.opcode   <= opcode;
            in_item_reg.frame_id <= frame_id;
            in_item_reg.length   <= length;
            in_item_reg.enhanced <= enhanced;
            in_item_reg.payload  <= payload;
            in_item_reg.rx_byte  <= rx_byte;
        end
    end

    lmfe_step #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_step (
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .st   (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE_STATE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = out_reg.tx_valid;
    assign tx_byte       = out_reg.tx_byte;
    assign baud_select   = out_reg.baud_select;
    assign break_request = out_reg.break_request;
    assign done_status   = out_reg.done_status;
    assign rx_payload    = out_reg.rx_payload;
    assign done_pid      = out_reg.done_pid;
    assign done_length   = out_reg.done_length;

    // a held item is never lost while the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held item dropped");

    // any completion status leaves the frame state idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.done_status != ST_NONE) |=> (state_reg.phase == PH_IDLE))
        else $error("frame state not cleared after completion");

    // idle frame state carries no tick count or partial checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) |-> (state_reg.idle_ticks == 16'd0 &&
                                           state_reg.running_sum == 8'd0))
        else $error("idle state not clean");

    // remaining byte count never exceeds the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_left <= state_reg.frame_length)
        else $error("byte count beyond frame length");

    // a completed frame never transmits in the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.tx_valid && out_reg.done_status != ST_NONE))
        else $error("transmit together with completion");

endmodule

// File: sv/lmfe_step.sv
// next-state and result logic for one item of the lin master frame engine
module lmfe_step
    import lmfe_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  item_t   item,
    input  cfg_t    cfg,
    input  state_t  st,
    output state_t  nxt,
    output result_t res
);

    logic [3:0]  len;
    logic [3:0]  left_dec;
    logic [2:0]  idx;
    logic [15:0] ticks_inc;
    logic        fin;
    logic [2:0]  fin_status;
    logic [11:0] tx_total;
    logic [8:0]  tx_fold;

    always_comb
    begin
        nxt        = st;
        res        = '0;
        fin        = 1'b0;
        fin_status = ST_NONE;
        tx_total   = 12'd0;
        tx_fold    = 9'd0;

        len = item.length;
        if (len == 4'd0)
        begin
            len = 4'd1;
        end
        if (len > 4'(MAX_DATA_BYTES))
        begin
            len = 4'(MAX_DATA_BYTES);
        end

        left_dec  = st.bytes_left - 4'd1;
        idx       = 3'(st.frame_length - st.bytes_left);
        ticks_inc = (st.idle_ticks != TICKS_MAX) ? st.idle_ticks + 16'd1 : st.idle_ticks;

        case (item.opcode)
            OP_START_TX, OP_START_RX:
            begin
                nxt              = IDLE_STATE;
                nxt.sending      = (item.opcode == OP_START_TX);
                nxt.protected_id = make_pid(item.frame_id & ID_MASK);
                nxt.frame_length = len;
                nxt.bytes_left   = len;
                nxt.use_enhanced = item.enhanced;
                nxt.running_sum  = item.enhanced ? nxt.protected_id : 8'd0;
                if (item.opcode == OP_START_TX)
                begin
                    // checksum of the bytes in use, precomputed for the check phase
                    tx_total = item.enhanced ? 12'(nxt.protected_id) : 12'd0;
                    for (int i = 0; i < DATA_BYTES; i++)
                    begin
                        if (4'(i) < len)
                        begin
                            nxt.data_store[i] = item.payload[8*i +: 8];
                            tx_total          = tx_total + 12'(item.payload[8*i +: 8]);
                        end
                    end
                    // fold the carries back in, same as adding with end-around carry
                    tx_fold         = 9'(tx_total[7:0]) + 9'(tx_total[11:8]);
                    nxt.running_sum = ~(tx_fold[7:0] + 8'(tx_fold[8]));
                    nxt.tx_shift    = 64'(nxt.data_store);
                end
                nxt.phase = PH_BREAK;
                if (!cfg.hw_break)
                begin
                    res.baud_select = BAUD_SLOW;
                    res.tx_valid    = 1'b1;
                    res.tx_byte     = BREAK_BYTE;
                end
                else
                begin
                    res.break_request = 1'b1;
                end
            end

            OP_BYTE:
            begin
                nxt.idle_ticks = 16'd0;
                unique case (st.phase)
                    PH_IDLE:
                    begin
                    end
                    PH_BREAK:
                    begin
                        if (!cfg.hw_break)
                        begin
                            if (item.rx_byte == BREAK_BYTE)
                            begin
                                nxt.phase       = PH_SYNC;
                                res.baud_select = BAUD_RESTORE;
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = cfg.sync_byte;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = ST_MISMATCH;
                            end
                        end
                    end
                    PH_SYNC:
                    begin
                        if (item.rx_byte == cfg.sync_byte)
                        begin
                            nxt.phase    = PH_PID;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = st.protected_id;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            fin_status = ST_MISMATCH;
                        end
                    end
                    PH_PID:
                    begin
                        if (item.rx_byte != st.protected_id)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_MISMATCH;
                        end
                        else
                        begin
                            nxt.bytes_left = st.frame_length;
                            nxt.phase      = PH_DATA;
                            if (st.sending)
                            begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = st.tx_shift[7:0];
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (st.sending)
                        begin
                            // echo of the low byte of the shift copy, then move on
                            if (item.rx_byte != st.tx_shift[7:0])
                            begin
                                fin        = 1'b1;
                                fin_status = ST_MISMATCH;
                            end
                            else
                            begin
                                nxt.bytes_left = left_dec;
                                nxt.tx_shift   = st.tx_shift >> 8;
                                res.tx_valid   = 1'b1;
                                if (left_dec != 4'd0)
                                begin
                                    res.tx_byte = st.tx_shift[15:8];
                                end
                                else
                                begin
                                    nxt.phase   = PH_CHECK;
                                    res.tx_byte = st.running_sum;
                                end
                            end
                        end
                        else
                        begin
                            nxt.data_store[idx] = item.rx_byte;
                            nxt.running_sum     = carry_add(st.running_sum, item.rx_byte);
                            nxt.bytes_left      = left_dec;
                            if (left_dec == 4'd0)
                            begin
                                nxt.phase = PH_CHECK;
                            end
                        end
                    end
                    PH_CHECK:
                    begin
                        fin = 1'b1;
                        if (st.sending)
                        begin
                            fin_status = (item.rx_byte == st.running_sum) ? ST_SENT
                                                                          : ST_MISMATCH;
                        end
                        else
                        begin
                            fin_status = (item.rx_byte == ~st.running_sum) ? ST_RECEIVED
                                                                           : ST_MISMATCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            OP_BREAK:
            begin
                if (cfg.hw_break)
                begin
                    if (st.phase == PH_BREAK)
                    begin
                        nxt.phase    = PH_SYNC;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = cfg.sync_byte;
                    end
                    else if (st.phase != PH_IDLE)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_MISMATCH;
                    end
                end
            end

            OP_TICK:
            begin
                if (st.phase != PH_IDLE)
                begin
                    nxt.idle_ticks = ticks_inc;
                    if (ticks_inc > cfg.timeout_limit)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_TIMEOUT;
                    end
                end
            end

            default:
            begin
            end
        endcase

        if (fin)
        begin
            if (fin_status == ST_SENT || fin_status == ST_RECEIVED)
            begin
                res.rx_payload = 64'(st.data_store);
            end
            // slow baud still active when the frame dies in the break phase
            if (!cfg.hw_break && st.phase == PH_BREAK)
            begin
                res.baud_select = BAUD_RESTORE;
            end
            res.done_status = fin_status;
            res.done_pid    = st.protected_id;
            res.done_length = st.frame_length;
            nxt             = IDLE_STATE;
        end
    end

endmodule
